// ===== rtl/flcs_pkg.sv =====
// Shared constants for the log-structured settings store.
// Page geometry, image size, header words and derived widths; no dependencies.
package flcs_pkg;

    localparam int PAGE_WORDS  = 512;
    localparam int IMAGE_WORDS = 32;

    localparam int PAGE_AW = $clog2(PAGE_WORDS);
    localparam int OFF_W   = $clog2(PAGE_WORDS) + 1;
    localparam int IMG_AW  = $clog2(IMAGE_WORDS);
    localparam int CNT_W   = $clog2(IMAGE_WORDS + 1);
    localparam int IDX_W   = 5;
    localparam int WORD_W  = 32;

    localparam logic [WORD_W-1:0] HDR_WORD0   = 32'hA0A0A0A0;
    localparam logic [WORD_W-1:0] HDR_WORD1   = 32'h0123ABCD;
    localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFFFFFF;

    localparam logic [1:0] ST_PLAIN    = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_APPENDED = 2'd2;
    localparam logic [1:0] ST_ERASED   = 2'd3;

endpackage

// ===== rtl/flcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module flcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/flash_log_config_store.sv =====
// Top level of the log-structured settings store: sequencer plus page, staging
// and active-image RAMs. Depends on flcs_pkg and flcs_ram.
//
// Usage: items arrive on the s_ stream (tuser = op, tlast = commit marker),
// one result word per item leaves on the m_ stream.
// op 0 reads a settings word: header check then a walk of the log, one logged
// entry at a time, up to the first erased word or the end of the page.
// op 1 stages a word; with tlast it also commits: header check, log walk, a compare
// pass over the image and an append pass over every index that writes an index word
// and a value word for each changed one.
// A bad header formats the page: an erase sweep over all 512 words and two header
// writes. A commit that does not fit erases the same way before appending.
// The page RAM has a single read port, shared by the header check and the log walk.
// After reset the block runs a sweep that fills all 512 page words with ones;
// s_tready stays low meanwhile.
// A result waits in the output register while m_tready is low; the next item
// may be accepted and worked on, and its result is held until the output
// register frees up.
module flash_log_config_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // index[4:0], new_value[36:5], default_value[68:37], zero pad
    input  logic        s_tuser,   // op
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // value[31:0], status[33:32], formatted[34], zero pad
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_HDR0   = 5'd1;
    localparam logic [4:0] S_HDR1   = 5'd2;
    localparam logic [4:0] S_IDLE   = 5'd3;
    localparam logic [4:0] S_HRD0   = 5'd4;
    localparam logic [4:0] S_HRD1   = 5'd5;
    localparam logic [4:0] S_HCHK   = 5'd6;
    localparam logic [4:0] S_SCA    = 5'd7;
    localparam logic [4:0] S_SCAW   = 5'd8;
    localparam logic [4:0] S_SCV    = 5'd9;
    localparam logic [4:0] S_CMPRD  = 5'd10;
    localparam logic [4:0] S_CMPCK  = 5'd11;
    localparam logic [4:0] S_APPRD  = 5'd12;
    localparam logic [4:0] S_APPCK  = 5'd13;
    localparam logic [4:0] S_APPW2  = 5'd14;
    localparam logic [4:0] S_DONE   = 5'd15;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_READ = 2'd1;
    localparam logic [1:0] RET_SCAN = 2'd2;
    localparam logic [1:0] RET_APP  = 2'd3;

    localparam int OW = flcs_pkg::OFF_W;
    localparam int IA = flcs_pkg::IMG_AW;
    localparam int WW = flcs_pkg::WORD_W;

    logic [4:0]              state_reg;
    logic [1:0]              ret_reg;
    logic [OW-1:0]           off_reg;
    logic [IA-1:0]           img_reg;
    logic [flcs_pkg::CNT_W-1:0] chg_reg;
    logic [flcs_pkg::IMAGE_WORDS-1:0] logged_reg;
    logic [WW-1:0]           a_reg;
    logic [WW-1:0]           found_reg;
    logic [WW-1:0]           dval_reg;
    logic [flcs_pkg::IDX_W-1:0] key_reg;
    logic                    op_reg;
    logic                    fmt_reg;
    logic                    erased_reg;
    logic                    hdr0_ok_reg;
    logic [WW-1:0]           res_value_reg;
    logic [1:0]              res_status_reg;
    logic                    res_fmt_reg;
    logic                    m_tvalid_reg;
    logic [39:0]             m_tdata_reg;

    logic [flcs_pkg::IDX_W-1:0] s_index;
    logic [WW-1:0]           s_new_value;
    logic [WW-1:0]           s_default_value;
    logic                    accept;

    logic                    pg_we;
    logic [flcs_pkg::PAGE_AW-1:0] pg_waddr;
    logic [WW-1:0]           pg_wdata;
    logic [flcs_pkg::PAGE_AW-1:0] pg_raddr;
    logic [WW-1:0]           pg_rdata;

    logic                    st_we;
    logic [2*WW-1:0]         st_rdata;
    logic                    act_we;
    logic [WW-1:0]           act_rdata;

    logic [OW-1:0]           off_p1;
    logic [OW-1:0]           off_p2;
    logic                    room;
    logic [WW-1:0]           act_val;
    logic                    diff;
    logic                    img_last;
    logic [flcs_pkg::CNT_W-1:0] chg_next;
    logic [OW-1:0]           free_pairs;
    logic                    a_in_image;
    logic                    out_free;

    assign s_index         = s_tdata[4:0];
    assign s_new_value     = s_tdata[36:5];
    assign s_default_value = s_tdata[68:37];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign off_p1     = off_reg + OW'(1);
    assign off_p2     = off_reg + OW'(2);
    assign room       = off_p1 < OW'(flcs_pkg::PAGE_WORDS);
    assign act_val    = logged_reg[img_reg] ? act_rdata : st_rdata[2*WW-1:WW];
    assign diff       = st_rdata[WW-1:0] != act_val;
    assign img_last   = img_reg == IA'(flcs_pkg::IMAGE_WORDS - 1);
    assign chg_next   = chg_reg + {{(flcs_pkg::CNT_W-1){1'b0}}, diff};
    assign free_pairs = (OW'(flcs_pkg::PAGE_WORDS) - off_reg) >> 1;
    assign a_in_image = a_reg < WW'(flcs_pkg::IMAGE_WORDS);

    assign st_we  = accept && s_tuser && (WW'(s_index) < WW'(flcs_pkg::IMAGE_WORDS));
    assign act_we = (state_reg == S_SCV) && op_reg && a_in_image;

    // Page port steering
    always_comb
    begin
        pg_we    = 1'b0;
        pg_waddr = off_reg[flcs_pkg::PAGE_AW-1:0];
        pg_wdata = flcs_pkg::ERASED_WORD;
        pg_raddr = off_reg[flcs_pkg::PAGE_AW-1:0];
        unique case (state_reg)
            S_CLR:
            begin
                pg_we = 1'b1;
            end
            S_HDR0:
            begin
                pg_we    = 1'b1;
                pg_waddr = '0;
                pg_wdata = flcs_pkg::HDR_WORD0;
            end
            S_HDR1:
            begin
                pg_we    = 1'b1;
                pg_waddr = flcs_pkg::PAGE_AW'(1);
                pg_wdata = flcs_pkg::HDR_WORD1;
            end
            S_HRD0:
            begin
                pg_raddr = '0;
            end
            S_HRD1:
            begin
                pg_raddr = flcs_pkg::PAGE_AW'(1);
            end
            S_SCAW:
            begin
                pg_raddr = off_p1[flcs_pkg::PAGE_AW-1:0];
            end
            S_APPCK:
            begin
                pg_we    = diff && room;
                pg_wdata = WW'(img_reg);
            end
            S_APPW2:
            begin
                pg_we    = 1'b1;
                pg_waddr = off_p1[flcs_pkg::PAGE_AW-1:0];
                pg_wdata = st_rdata[WW-1:0];
            end
            default:
            begin
                pg_we = 1'b0;
            end
        endcase
    end

    flcs_ram #(
        .WIDTH (WW),
        .DEPTH (flcs_pkg::PAGE_WORDS),
        .AW    (flcs_pkg::PAGE_AW)
    ) u_page (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    // Staged image: default in the upper half, new value in the lower half
    flcs_ram #(
        .WIDTH (2 * WW),
        .DEPTH (flcs_pkg::IMAGE_WORDS),
        .AW    (IA)
    ) u_stage (
        .clk   (clk),
        .we    (st_we),
        .waddr (s_index[IA-1:0]),
        .wdata ({s_default_value, s_new_value}),
        .raddr (img_reg),
        .rdata (st_rdata)
    );

    flcs_ram #(
        .WIDTH (WW),
        .DEPTH (flcs_pkg::IMAGE_WORDS),
        .AW    (IA)
    ) u_active (
        .clk   (clk),
        .we    (act_we),
        .waddr (a_reg[IA-1:0]),
        .wdata (pg_rdata),
        .raddr (img_reg),
        .rdata (act_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            ret_reg        <= RET_IDLE;
            off_reg        <= '0;
            img_reg        <= '0;
            chg_reg        <= '0;
            logged_reg     <= '0;
            op_reg         <= 1'b0;
            fmt_reg        <= 1'b0;
            erased_reg     <= 1'b0;
            hdr0_ok_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            a_reg          <= '0;
            found_reg      <= '0;
            dval_reg       <= '0;
            key_reg        <= '0;
            res_value_reg  <= '0;
            res_status_reg <= flcs_pkg::ST_PLAIN;
            res_fmt_reg    <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    off_reg <= off_p1;
                    if (off_reg == OW'(flcs_pkg::PAGE_WORDS - 1))
                    begin
                        state_reg <= (ret_reg == RET_IDLE) ? S_IDLE : S_HDR0;
                    end
                end
                S_HDR0:
                begin
                    state_reg <= S_HDR1;
                end
                S_HDR1:
                begin
                    off_reg    <= OW'(2);
                    logged_reg <= '0;
                    img_reg    <= '0;
                    chg_reg    <= '0;
                    unique case (ret_reg)
                        RET_READ:
                        begin
                            res_value_reg  <= dval_reg;
                            res_status_reg <= flcs_pkg::ST_PLAIN;
                            res_fmt_reg    <= 1'b1;
                            state_reg      <= S_DONE;
                        end
                        RET_SCAN:
                        begin
                            // log is empty: go straight to the compare pass
                            state_reg <= S_CMPRD;
                        end
                        RET_APP:
                        begin
                            state_reg <= S_APPRD;
                        end
                        RET_IDLE:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= s_tuser;
                        key_reg    <= s_index;
                        dval_reg   <= s_default_value;
                        fmt_reg    <= 1'b0;
                        erased_reg <= 1'b0;
                        if (!s_tuser || s_tlast)
                        begin
                            state_reg <= S_HRD0;
                        end
                        else
                        begin
                            res_value_reg  <= '0;
                            res_status_reg <= flcs_pkg::ST_PLAIN;
                            res_fmt_reg    <= 1'b0;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_HRD0:
                begin
                    state_reg <= S_HRD1;
                end
                S_HRD1:
                begin
                    hdr0_ok_reg <= pg_rdata == flcs_pkg::HDR_WORD0;
                    state_reg   <= S_HCHK;
                end
                S_HCHK:
                begin
                    if (hdr0_ok_reg && (pg_rdata == flcs_pkg::HDR_WORD1))
                    begin
                        off_reg    <= OW'(2);
                        logged_reg <= '0;
                        found_reg  <= dval_reg;
                        state_reg  <= S_SCA;
                    end
                    else
                    begin
                        fmt_reg   <= 1'b1;
                        off_reg   <= '0;
                        ret_reg   <= op_reg ? RET_SCAN : RET_READ;
                        state_reg <= S_CLR;
                    end
                end
                S_SCA:
                begin
                    if (room)
                    begin
                        state_reg <= S_SCAW;
                    end
                    else if (!op_reg)
                    begin
                        res_value_reg  <= found_reg;
                        res_status_reg <= flcs_pkg::ST_PLAIN;
                        res_fmt_reg    <= fmt_reg;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        img_reg   <= '0;
                        chg_reg   <= '0;
                        state_reg <= S_CMPRD;
                    end
                end
                S_SCAW:
                begin
                    a_reg <= pg_rdata;
                    if (pg_rdata != flcs_pkg::ERASED_WORD)
                    begin
                        state_reg <= S_SCV;
                    end
                    else if (!op_reg)
                    begin
                        res_value_reg  <= found_reg;
                        res_status_reg <= flcs_pkg::ST_PLAIN;
                        res_fmt_reg    <= fmt_reg;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        img_reg   <= '0;
                        chg_reg   <= '0;
                        state_reg <= S_CMPRD;
                    end
                end
                S_SCV:
                begin
                    if (!op_reg && (a_reg == WW'(key_reg)))
                    begin
                        found_reg <= pg_rdata;
                    end
                    if (act_we)
                    begin
                        logged_reg[a_reg[IA-1:0]] <= 1'b1;
                    end
                    off_reg   <= off_p2;
                    state_reg <= S_SCA;
                end
                S_CMPRD:
                begin
                    state_reg <= S_CMPCK;
                end
                S_CMPCK:
                begin
                    chg_reg <= chg_next;
                    if (!img_last)
                    begin
                        img_reg   <= img_reg + IA'(1);
                        state_reg <= S_CMPRD;
                    end
                    else if (chg_next == '0)
                    begin
                        res_value_reg  <= '0;
                        res_status_reg <= flcs_pkg::ST_NOCHANGE;
                        res_fmt_reg    <= fmt_reg;
                        state_reg      <= S_DONE;
                    end
                    else if (free_pairs < OW'(chg_next))
                    begin
                        // no room: erase, re-head, append against defaults
                        erased_reg <= 1'b1;
                        off_reg    <= '0;
                        ret_reg    <= RET_APP;
                        state_reg  <= S_CLR;
                    end
                    else
                    begin
                        img_reg   <= '0;
                        state_reg <= S_APPRD;
                    end
                end
                S_APPRD:
                begin
                    state_reg <= S_APPCK;
                end
                S_APPCK, S_APPW2:
                begin
                    if ((state_reg == S_APPCK) && diff && room)
                    begin
                        state_reg <= S_APPW2;
                    end
                    else
                    begin
                        if (state_reg == S_APPW2)
                        begin
                            off_reg <= off_p2;
                        end
                        if (img_last)
                        begin
                            res_value_reg  <= '0;
                            res_status_reg <= erased_reg ? flcs_pkg::ST_ERASED
                                                         : flcs_pkg::ST_APPENDED;
                            res_fmt_reg    <= fmt_reg;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            img_reg   <= img_reg + IA'(1);
                            state_reg <= S_APPRD;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg <= {5'b0, res_fmt_reg, res_status_reg, res_value_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_off_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg <= OW'(flcs_pkg::PAGE_WORDS))
        else $error("log offset beyond page");

    a_value_word_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPW2) |-> (pg_we && pg_waddr[0]))
        else $error("value word written at even address");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && m_tvalid && !m_tready) |=> (state_reg == S_DONE))
        else $error("result overwrote a waiting word");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !s_tready)
        else $error("item taken during erase sweep");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for flash_log_config_store: directed table then random traffic.
// Predicts every result word with an in-bench page model; depends on flcs_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 560;

    typedef struct packed {
        logic        op;
        logic [4:0]  index;
        logic [31:0] new_value;
        logic [31:0] default_value;
        logic        last;
    } store_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        formatted;
    } store_rsp_t;

    typedef struct {
        store_req_t req;
        logic       typed;
        store_rsp_t rsp;
    } table_row_t;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_STAGE = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // index, new_value, default_value, zero pad
    logic        s_tuser;   // op
    logic        s_tlast;   // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // value, status, formatted, zero pad

    flash_log_config_store dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [31:0] page_mem [flcs_pkg::PAGE_WORDS];
    int          append_ptr;
    logic [31:0] stage_val [flcs_pkg::IMAGE_WORDS];
    logic [31:0] stage_def [flcs_pkg::IMAGE_WORDS];
    logic [31:0] live_image [flcs_pkg::IMAGE_WORDS];

    store_rsp_t  expected_words[$];
    int          error_count = 0;
    int          idle_cycles;
    int          stall_left = 0;
    bit          stim_done;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void page_format();
        for (int k = 0; k < flcs_pkg::PAGE_WORDS; k++)
            page_mem[k] = flcs_pkg::ERASED_WORD;
        page_mem[0] = flcs_pkg::HDR_WORD0;
        page_mem[1] = flcs_pkg::HDR_WORD1;
        append_ptr = 2;
    endfunction

    function automatic logic header_fix();
        if (page_mem[0] !== flcs_pkg::HDR_WORD0 || page_mem[1] !== flcs_pkg::HDR_WORD1)
        begin
            page_format();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // walk the log: last value for key, optionally rebuild the live image
    function automatic logic walk_log(input logic [31:0] key, inout logic [31:0] hit_val,
                                      input bit fill);
        int off;
        logic hit;
        hit = 1'b0;
        for (off = 2; off + 1 < flcs_pkg::PAGE_WORDS; off += 2)
        begin
            if (page_mem[off] == flcs_pkg::ERASED_WORD)
                break;
            if (page_mem[off] == key)
            begin
                hit_val = page_mem[off+1];
                hit = 1'b1;
            end
            if (fill && page_mem[off] < flcs_pkg::IMAGE_WORDS)
                live_image[page_mem[off]] = page_mem[off+1];
        end
        append_ptr = off;
        return hit;
    endfunction

    function automatic store_rsp_t predict_store(input store_req_t r);
        store_rsp_t o;
        logic [31:0] found;
        int changes, freepairs;
        bit erased;
        o = '0;
        if (r.op == OP_READ)
        begin
            found = r.default_value;
            o.formatted = header_fix();
            if (!o.formatted)
                void'(walk_log({27'd0, r.index}, found, 1'b0));
            o.value = found;
            o.status = flcs_pkg::ST_PLAIN;
            return o;
        end
        if (r.index < flcs_pkg::IMAGE_WORDS)
        begin
            stage_val[r.index] = r.new_value;
            stage_def[r.index] = r.default_value;
        end
        o.status = flcs_pkg::ST_PLAIN;
        if (!r.last)
            return o;
        o.formatted = header_fix();
        for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
            live_image[i] = stage_def[i];
        found = '0;
        void'(walk_log(flcs_pkg::ERASED_WORD, found, 1'b1));
        changes = 0;
        for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
            if (stage_val[i] != live_image[i])
                changes++;
        if (changes == 0)
        begin
            o.status = flcs_pkg::ST_NOCHANGE;
            return o;
        end
        freepairs = (append_ptr < flcs_pkg::PAGE_WORDS)
                        ? (flcs_pkg::PAGE_WORDS - append_ptr) / 2 : 0;
        erased = 0;
        if (freepairs < changes)
        begin
            page_format();
            for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
                live_image[i] = stage_def[i];
            erased = 1;
        end
        for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
            if (stage_val[i] != live_image[i])
            begin
                if (append_ptr + 1 >= flcs_pkg::PAGE_WORDS)
                    break;
                page_mem[append_ptr] = i;
                page_mem[append_ptr+1] = stage_val[i];
                append_ptr += 2;
            end
        o.status = erased ? flcs_pkg::ST_ERASED : flcs_pkg::ST_APPENDED;
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // drive one word, hold until accepted; keep valid high when no gap follows
    task automatic send_word(input store_req_t r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tlast  <= r.last;
        s_tdata  <= {3'd0, r.default_value, r.new_value, r.index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_words.push_back(predict_store(r));
    endtask

    // full image stage with commit; change_pct sets the share of words that differ from the default
    task automatic send_image(input int change_pct, input logic [31:0] dbase);
        store_req_t r;
        for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
        begin
            r.op = OP_STAGE;
            r.index = 5'(i);
            r.default_value = dbase ^ i;
            r.new_value = ($urandom_range(0, 99) < change_pct) ? $urandom() : r.default_value;
            r.last = (i == flcs_pkg::IMAGE_WORDS - 1);
            send_word(r);
        end
    endtask

    task automatic send_read();
        store_req_t r;
        r.op = OP_READ;
        r.index = 5'($urandom_range(0, 31));
        r.new_value = $urandom();
        r.default_value = $urandom();
        r.last = 1'($urandom_range(0, 1));
        send_word(r);
    endtask

    // result side: random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        store_rsp_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.value     = m_tdata[31:0];
                got.status    = m_tdata[33:32];
                got.formatted = m_tdata[34];
                if (expected_words.size() == 0)
                begin
                    $display("unexpected result word %h at %0t", m_tdata, $time);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.formatted !== want.formatted)
                        report_mismatch("formatted", 32'(got.formatted),
                                        32'(want.formatted));
                    if (m_tdata[39:35] !== 5'd0)
                        report_mismatch("pad", 32'(m_tdata[39:35]), 32'd0);
                end
            end
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(20, 80);
            end
            else
                m_tready <= $urandom_range(0, 99) < 70;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    table_row_t dir_rows[$];

    initial
    begin
        table_row_t row;
        store_rsp_t want;
        int wait_cnt;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        stim_done = 0;
        for (int k = 0; k < flcs_pkg::PAGE_WORDS; k++)
            page_mem[k] = flcs_pkg::ERASED_WORD;
        append_ptr = 2;
        for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
        begin
            stage_val[i] = '0;
            stage_def[i] = '0;
            live_image[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: blank page read formats; then extremes and last-on-read
        dir_rows.push_back('{'{OP_READ, 5'd0, 32'h0, 32'hFFFFFFFF, 1'b0}, 1'b1,
                             '{32'hFFFFFFFF, flcs_pkg::ST_PLAIN, 1'b1}});
        dir_rows.push_back('{'{OP_READ, 5'd31, 32'hFFFFFFFF, 32'h00000000, 1'b1}, 1'b1,
                             '{32'h0, flcs_pkg::ST_PLAIN, 1'b0}});
        dir_rows.push_back('{'{OP_STAGE, 5'd31, 32'hFFFFFFFF, 32'h0, 1'b0}, 1'b1,
                             '{32'h0, flcs_pkg::ST_PLAIN, 1'b0}});
        foreach (dir_rows[n])
        begin
            row = dir_rows[n];
            send_word(row.req);
            want = expected_words[$];
            if (row.typed && want.value !== row.rsp.value)
                report_mismatch("row value", want.value, row.rsp.value);
            if (row.typed && want.status !== row.rsp.status)
                report_mismatch("row status", 32'(want.status), 32'(row.rsp.status));
            if (row.typed && want.formatted !== row.rsp.formatted)
                report_mismatch("row formatted", 32'(want.formatted),
                                32'(row.rsp.formatted));
        end
        // a no-change commit (staged equals default), then one appending
        for (int i = 0; i < flcs_pkg::IMAGE_WORDS; i++)
            send_word('{OP_STAGE, 5'(i), 32'h0, 32'h0, 5'(i) == 5'd31});
        send_word('{OP_STAGE, 5'd0, 32'hFFFFFFFF, 32'h0, 1'b1});
        send_word('{OP_READ, 5'd0, 32'h0, 32'h5A5A5A5A, 1'b0});

        // random: image commits with mixed change rates, single stages and reads between
        for (int n = 0; n < N_RANDOM; )
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_image($urandom_range(0, 1) ? 100 : $urandom_range(0, 30),
                           $urandom_range(0, 3) == 0 ? $urandom() : 32'h0);
                n += flcs_pkg::IMAGE_WORDS;
            end
            else if (pick < 25)
            begin
                store_req_t r;
                r.op = OP_STAGE;
                r.index = 5'($urandom_range(0, 31));
                r.new_value = $urandom();
                r.default_value = $urandom_range(0, 1) ? stage_def[r.index] : $urandom();
                r.last = $urandom_range(0, 3) == 0;
                send_word(r);
                n++;
            end
            else
            begin
                send_read();
                n++;
            end
        end
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (expected_words.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        stim_done = 1;
        repeat (1500) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/flcs_pkg.sv
rtl/flcs_ram.sv
rtl/flash_log_config_store.sv
test/testbench.sv
